/* sv/lsat_pkg.sv */
`timescale 1ns / 1ps
// Shared constants and types for the largest slice area tracker.
package lsat_pkg;

    localparam int DIM_SIZE    = 512;
    localparam int COORD_W     = 9;
    localparam int FACE_W      = 16;
    localparam int AREA_W      = 40;
    localparam int AXIS_W      = 2;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int OUTQ_DEPTH  = 3;

    localparam logic [FACE_W-1:0] FACE_RESET = 16'd256;

    localparam logic [CFG_IDX_W-1:0] CFG_AREA_YZ = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_XZ = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AREA_XY = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_X  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_Y  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_Z  = 3'd5;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    typedef struct packed {
        logic clr;
        logic upd;
    } lane_ctl_t;

    typedef struct packed {
        logic [AREA_W-1:0]  best_area;
        logic [AXIS_W-1:0]  best_axis;
        logic [COORD_W-1:0] best_slice;
        logic               found;
    } result_t;

endpackage

/* sv/lsat_if.sv */
`timescale 1ns / 1ps
// Request and result channel interfaces for the slice area tracker.
interface lsat_vox_if;
    logic                        valid;
    logic                        ready;
    logic [lsat_pkg::COORD_W-1:0] vox_x;
    logic [lsat_pkg::COORD_W-1:0] vox_y;
    logic [lsat_pkg::COORD_W-1:0] vox_z;
    logic                        inside_req;

    modport source (output valid, vox_x, vox_y, vox_z, inside_req, input ready);
    modport sink   (input valid, vox_x, vox_y, vox_z, inside_req, output ready);
endinterface

interface lsat_best_if;
    logic                         valid;
    logic                         ready;
    logic [lsat_pkg::AREA_W-1:0]  best_area;
    logic [lsat_pkg::AXIS_W-1:0]  best_axis;
    logic [lsat_pkg::COORD_W-1:0] best_slice;
    logic                         found;

    modport source (output valid, best_area, best_axis, best_slice, found, input ready);
    modport sink   (input valid, best_area, best_axis, best_slice, found, output ready);
endinterface

/* sv/lsat_ram.sv */
`timescale 1ns / 1ps
// Generic single write port RAM with registered read.
module lsat_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 512,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* sv/lsat_lane.sv */
`timescale 1ns / 1ps
// One axis of slice accumulators: storage, write forwarding and saturating add.
module lsat_lane #(
    parameter int DIM_SIZE = lsat_pkg::DIM_SIZE,
    localparam int AW = (DIM_SIZE > 1) ? $clog2(DIM_SIZE) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  lsat_pkg::lane_ctl_t          ctl,
    input  logic [AW-1:0]                rd_addr,
    input  logic [AW-1:0]                upd_addr,
    input  logic [AW-1:0]                clr_addr,
    input  logic [lsat_pkg::FACE_W-1:0]  face,
    output logic [lsat_pkg::AREA_W-1:0]  sum
);

    logic [lsat_pkg::AREA_W-1:0] rdata;
    logic [lsat_pkg::AREA_W-1:0] acc;
    logic [lsat_pkg::AREA_W:0]   sum_wide;
    logic                        we;
    logic [AW-1:0]               waddr;
    logic [lsat_pkg::AREA_W-1:0] wdata;

    logic                        fwd_valid_reg;
    logic [AW-1:0]               fwd_addr_reg;
    logic [lsat_pkg::AREA_W-1:0] fwd_data_reg;

    // The read for this request was issued on the same edge that stored the
    // previous update, so take that update when the slice matches.
    assign acc = (fwd_valid_reg && (fwd_addr_reg == upd_addr)) ? fwd_data_reg : rdata;

    assign sum_wide = {1'b0, acc} + (lsat_pkg::AREA_W + 1)'(face);
    assign sum      = sum_wide[lsat_pkg::AREA_W] ? '1 : sum_wide[lsat_pkg::AREA_W-1:0];

    assign we    = ctl.clr || ctl.upd;
    assign waddr = ctl.clr ? clr_addr : upd_addr;
    assign wdata = ctl.clr ? '0 : sum;

    lsat_ram #(
        .WIDTH (lsat_pkg::AREA_W),
        .DEPTH (DIM_SIZE)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (rd_addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            fwd_valid_reg <= ctl.upd;
        end
    end

    always_ff @(posedge clk)
    begin
        fwd_addr_reg <= upd_addr;
        fwd_data_reg <= sum;
    end

endmodule

/* sv/lsat_outq.sv */
`timescale 1ns / 1ps
// Small result queue that decouples the update stage from the result channel.
module lsat_outq (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lsat_pkg::result_t  push_data,
    output logic [$clog2(lsat_pkg::OUTQ_DEPTH+1)-1:0] level,
    lsat_best_if.source        best
);

    localparam int DEPTH = lsat_pkg::OUTQ_DEPTH;
    localparam int PW    = $clog2(DEPTH);
    localparam int LW    = $clog2(DEPTH + 1);

    lsat_pkg::result_t entry_reg [DEPTH];
    logic [PW-1:0]     wr_ptr_reg;
    logic [PW-1:0]     wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg;
    logic [PW-1:0]     rd_ptr_next;
    logic [LW-1:0]     level_reg;
    logic [LW-1:0]     level_next;
    logic              pop;
    lsat_pkg::result_t head;

    assign pop   = best.valid && best.ready;
    assign level = level_reg;
    assign head  = entry_reg[rd_ptr_reg];

    assign best.valid      = (level_reg != '0);
    assign best.best_area  = head.best_area;
    assign best.best_axis  = head.best_axis;
    assign best.best_slice = head.best_slice;
    assign best.found      = head.found;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        level_next  = level_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            level_next = level_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* sv/largest_slice_area_tracker_top.sv */
`timescale 1ns / 1ps
// Largest slice area tracker: region check, per-axis accumulators, best-slice selection.
// Flow: the accumulators are read on the edge that accepts a request, the update stage
// registers it, then update and select push the result into the result queue.
// Throughput: one request per cycle while ready is high (no clearing pass, queue has room);
// the accumulator read-modify-write sets this, with forwarding between consecutive updates of the same slice.
// Reset: after rst_n rises the accumulators are cleared one slice per cycle, with ready
// low until every slice is cleared; configuration writes are taken meanwhile.
module largest_slice_area_tracker_top #(
    parameter int DIM_SIZE = lsat_pkg::DIM_SIZE
) (
    input  logic                              clk,
    input  logic                              rst_n,
    lsat_vox_if.sink                          vox,
    lsat_best_if.source                       best,
    input  logic                              cfg_wr_en,
    input  logic [lsat_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [lsat_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int AW = (DIM_SIZE > 1) ? $clog2(DIM_SIZE) : 1;
    localparam int LW = $clog2(lsat_pkg::OUTQ_DEPTH + 1);
    localparam int CW = lsat_pkg::COORD_W;
    localparam int RW = lsat_pkg::AREA_W;

    // configuration
    logic [lsat_pkg::FACE_W-1:0] area_yz_reg;
    logic [lsat_pkg::FACE_W-1:0] area_xz_reg;
    logic [lsat_pkg::FACE_W-1:0] area_xy_reg;
    logic [CW-1:0]               base_x_reg;
    logic [CW-1:0]               base_y_reg;
    logic [CW-1:0]               base_z_reg;

    // clearing pass
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    // request acceptance
    logic          accept;
    logic          in_region;
    logic [CW-1:0] off_x;
    logic [CW-1:0] off_y;
    logic [CW-1:0] off_z;
    logic [AW-1:0] idx_x;
    logic [AW-1:0] idx_y;
    logic [AW-1:0] idx_z;
    logic [LW:0]   occupancy;

    // update stage
    logic          s1_valid_reg;
    logic          s1_upd_reg;
    logic [CW-1:0] s1_x_reg;
    logic [CW-1:0] s1_y_reg;
    logic [CW-1:0] s1_z_reg;
    logic [AW-1:0] s1_idx_x_reg;
    logic [AW-1:0] s1_idx_y_reg;
    logic [AW-1:0] s1_idx_z_reg;

    lsat_pkg::lane_ctl_t lane_ctl;
    logic [RW-1:0] sum_x;
    logic [RW-1:0] sum_y;
    logic [RW-1:0] sum_z;

    // running best
    logic [RW-1:0]               max_area_reg;
    logic [RW-1:0]               max_area_next;
    logic [lsat_pkg::AXIS_W-1:0] max_axis_reg;
    logic [lsat_pkg::AXIS_W-1:0] max_axis_next;
    logic [CW-1:0]               max_slice_reg;
    logic [CW-1:0]               max_slice_next;
    logic                        seen_reg;
    logic                        seen_next;
    logic                        win_x;
    logic                        win_y;
    logic                        win_z;

    lsat_pkg::result_t result;
    logic [LW-1:0]     q_level;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            area_yz_reg <= lsat_pkg::FACE_RESET;
            area_xz_reg <= lsat_pkg::FACE_RESET;
            area_xy_reg <= lsat_pkg::FACE_RESET;
            base_x_reg  <= '0;
            base_y_reg  <= '0;
            base_z_reg  <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lsat_pkg::CFG_AREA_YZ: area_yz_reg <= cfg_data;
                lsat_pkg::CFG_AREA_XZ: area_xz_reg <= cfg_data;
                lsat_pkg::CFG_AREA_XY: area_xy_reg <= cfg_data;
                lsat_pkg::CFG_BASE_X:  base_x_reg  <= cfg_data[CW-1:0];
                lsat_pkg::CFG_BASE_Y:  base_y_reg  <= cfg_data[CW-1:0];
                lsat_pkg::CFG_BASE_Z:  base_z_reg  <= cfg_data[CW-1:0];
                default: ;
            endcase
        end
    end

    // sweep the accumulators to zero after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(DIM_SIZE - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // hold off requests during the clearing pass and while the queue could not take the one in flight
    assign occupancy = (LW + 1)'(q_level) + (LW + 1)'(s1_valid_reg);
    assign vox.ready = !clr_busy_reg && (occupancy < (LW + 1)'(lsat_pkg::OUTQ_DEPTH));
    assign accept    = vox.valid && vox.ready;

    assign in_region = (vox.vox_x >= base_x_reg) && (vox.vox_y >= base_y_reg) &&
                       (vox.vox_z >= base_z_reg) &&
                       (int'(vox.vox_x) < DIM_SIZE) && (int'(vox.vox_y) < DIM_SIZE) &&
                       (int'(vox.vox_z) < DIM_SIZE);

    assign off_x = vox.vox_x - base_x_reg;
    assign off_y = vox.vox_y - base_y_reg;
    assign off_z = vox.vox_z - base_z_reg;
    assign idx_x = AW'(off_x);
    assign idx_y = AW'(off_y);
    assign idx_z = AW'(off_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_upd_reg   <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            s1_upd_reg   <= accept && vox.inside_req && in_region;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_x_reg     <= vox.vox_x;
            s1_y_reg     <= vox.vox_y;
            s1_z_reg     <= vox.vox_z;
            s1_idx_x_reg <= idx_x;
            s1_idx_y_reg <= idx_y;
            s1_idx_z_reg <= idx_z;
        end
    end

    assign lane_ctl.clr = clr_busy_reg;
    assign lane_ctl.upd = s1_upd_reg;

    lsat_lane #(.DIM_SIZE(DIM_SIZE)) u_lane_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (lane_ctl),
        .rd_addr  (idx_x),
        .upd_addr (s1_idx_x_reg),
        .clr_addr (clr_addr_reg),
        .face     (area_yz_reg),
        .sum      (sum_x)
    );

    lsat_lane #(.DIM_SIZE(DIM_SIZE)) u_lane_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (lane_ctl),
        .rd_addr  (idx_y),
        .upd_addr (s1_idx_y_reg),
        .clr_addr (clr_addr_reg),
        .face     (area_xz_reg),
        .sum      (sum_y)
    );

    lsat_lane #(.DIM_SIZE(DIM_SIZE)) u_lane_z (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (lane_ctl),
        .rd_addr  (idx_z),
        .upd_addr (s1_idx_z_reg),
        .clr_addr (clr_addr_reg),
        .face     (area_xy_reg),
        .sum      (sum_z)
    );

    // Parallel form of the x, y, z strict greater-than sequence: a later axis
    // wins only if it beats the old best and every earlier axis.
    assign win_z = (sum_z > max_area_reg) && (sum_z > sum_x) && (sum_z > sum_y);
    assign win_y = !win_z && (sum_y > max_area_reg) && (sum_y > sum_x);
    assign win_x = !win_z && !win_y && (sum_x > max_area_reg);

    always_comb
    begin
        max_area_next  = max_area_reg;
        max_axis_next  = max_axis_reg;
        max_slice_next = max_slice_reg;
        seen_next      = seen_reg;
        if (s1_upd_reg)
        begin
            seen_next = 1'b1;
            if (win_z)
            begin
                max_area_next  = sum_z;
                max_axis_next  = lsat_pkg::AXIS_Z;
                max_slice_next = s1_z_reg;
            end
            else if (win_y)
            begin
                max_area_next  = sum_y;
                max_axis_next  = lsat_pkg::AXIS_Y;
                max_slice_next = s1_y_reg;
            end
            else if (win_x)
            begin
                max_area_next  = sum_x;
                max_axis_next  = lsat_pkg::AXIS_X;
                max_slice_next = s1_x_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_area_reg  <= '0;
            max_axis_reg  <= lsat_pkg::AXIS_X;
            max_slice_reg <= '0;
            seen_reg      <= 1'b0;
        end
        else
        begin
            max_area_reg  <= max_area_next;
            max_axis_reg  <= max_axis_next;
            max_slice_reg <= max_slice_next;
            seen_reg      <= seen_next;
        end
    end

    assign result.best_area  = max_area_next;
    assign result.best_axis  = max_axis_next;
    assign result.best_slice = max_slice_next;
    assign result.found      = seen_next;

    lsat_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid_reg),
        .push_data (result),
        .level     (q_level),
        .best      (best)
    );

endmodule

/* sim/tb_largest_slice_area_tracker_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the largest slice area tracker top level.
module tb_largest_slice_area_tracker_top;
    import lsat_pkg::*;

    localparam int CLK_HALF        = 6;
    localparam int RESET_CYCLES    = 9;
    localparam int MAX_GAP         = 7;
    localparam int HOLD_CYCLES     = 80;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int TAIL_CYCLES     = 8;
    localparam int ITEMS_PER_PHASE = 75;
    localparam int RANDOM_PHASES   = 6;
    localparam int NEAR_SPAN       = 7;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_7 = 3'd7;
    localparam logic [FACE_W-1:0]    FACE_MAX    = '1;
    localparam logic [COORD_W-1:0]   COORD_MAX   = '1;
    localparam logic [AREA_W-1:0]    AREA_SAT    = '1;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    lsat_vox_if  vox_bus ();
    lsat_best_if best_bus ();

    largest_slice_area_tracker_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .vox       (vox_bus),
        .best      (best_bus),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Local copy of the configuration and the slice accumulators
    logic [FACE_W-1:0]  face_yz;
    logic [FACE_W-1:0]  face_xz;
    logic [FACE_W-1:0]  face_xy;
    logic [COORD_W-1:0] org_x;
    logic [COORD_W-1:0] org_y;
    logic [COORD_W-1:0] org_z;
    logic [AREA_W-1:0]  x_total [DIM_SIZE];
    logic [AREA_W-1:0]  y_total [DIM_SIZE];
    logic [AREA_W-1:0]  z_total [DIM_SIZE];
    result_t            best_now;
    result_t            best_q [$];

    int error_count;
    int idle_cycles;
    bit no_gaps;
    bit hold_req;

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    function automatic logic [AREA_W-1:0] sat_sum(input logic [AREA_W-1:0] acc,
                                                  input logic [FACE_W-1:0] face);
        logic [AREA_W:0] s;
        s = {1'b0, acc} + (AREA_W + 1)'(face);
        return s[AREA_W] ? AREA_SAT : s[AREA_W-1:0];
    endfunction

    // Strict greater-than: a tie keeps the earlier winner
    function void offer_slice(input logic [AREA_W-1:0] total, input logic [AXIS_W-1:0] axis,
                              input logic [COORD_W-1:0] slice);
        if (total > best_now.best_area)
        begin
            best_now.best_area  = total;
            best_now.best_axis  = axis;
            best_now.best_slice = slice;
        end
    endfunction

    function void track_voxel(input logic [COORD_W-1:0] vx, input logic [COORD_W-1:0] vy,
                              input logic [COORD_W-1:0] vz, input logic fg);
        logic [COORD_W-1:0] ox;
        logic [COORD_W-1:0] oy;
        logic [COORD_W-1:0] oz;
        if (fg && vx >= org_x && vy >= org_y && vz >= org_z &&
            int'(vx) < DIM_SIZE && int'(vy) < DIM_SIZE && int'(vz) < DIM_SIZE)
        begin
            ox = vx - org_x;
            oy = vy - org_y;
            oz = vz - org_z;
            x_total[ox] = sat_sum(x_total[ox], face_yz);
            y_total[oy] = sat_sum(y_total[oy], face_xz);
            z_total[oz] = sat_sum(z_total[oz], face_xy);
            offer_slice(x_total[ox], AXIS_X, vx);
            offer_slice(y_total[oy], AXIS_Y, vy);
            offer_slice(z_total[oz], AXIS_Z, vz);
            best_now.found = 1'b1;
        end
        best_q = {best_q, best_now};
    endfunction

    function void report_field(input string name, input logic [AREA_W-1:0] want,
                               input logic [AREA_W-1:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function automatic logic [COORD_W-1:0] near_base(input logic [COORD_W-1:0] base);
        int v;
        v = int'(base) + $urandom_range(0, NEAR_SPAN);
        return (v > int'(COORD_MAX)) ? COORD_MAX : v[COORD_W-1:0];
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_AREA_YZ: face_yz = data;
            CFG_AREA_XZ: face_xz = data;
            CFG_AREA_XY: face_xy = data;
            CFG_BASE_X:  org_x   = data[COORD_W-1:0];
            CFG_BASE_Y:  org_y   = data[COORD_W-1:0];
            CFG_BASE_Z:  org_z   = data[COORD_W-1:0];
            default: ;
        endcase
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_config(input logic [FACE_W-1:0] yz, input logic [FACE_W-1:0] xz,
                              input logic [FACE_W-1:0] xy, input logic [COORD_W-1:0] bx,
                              input logic [COORD_W-1:0] by, input logic [COORD_W-1:0] bz);
        write_reg(CFG_AREA_YZ, yz);
        write_reg(CFG_AREA_XZ, xz);
        write_reg(CFG_AREA_XY, xy);
        write_reg(CFG_BASE_X, CFG_DATA_W'(bx));
        write_reg(CFG_BASE_Y, CFG_DATA_W'(by));
        write_reg(CFG_BASE_Z, CFG_DATA_W'(bz));
    endtask

    // Drop valid and wait until every pending result has been taken
    task automatic drain();
        vox_bus.valid <= 1'b0;
        @(posedge clk);
        while (best_q.size() != 0) @(posedge clk);
        @(posedge clk);
    endtask

    task automatic send_voxel(input logic [COORD_W-1:0] vx, input logic [COORD_W-1:0] vy,
                              input logic [COORD_W-1:0] vz, input logic fg);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            vox_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vox_bus.valid      <= 1'b1;
        vox_bus.vox_x      <= vx;
        vox_bus.vox_y      <= vy;
        vox_bus.vox_z      <= vz;
        vox_bus.inside_req <= fg;
        @(posedge clk);
        while (vox_bus.ready !== 1'b1) @(posedge clk);
        track_voxel(vx, vy, vz, fg);
    endtask

    task automatic send_random_voxel();
        int                 pick;
        int                 axis_pick;
        logic [COORD_W-1:0] vx;
        logic [COORD_W-1:0] vy;
        logic [COORD_W-1:0] vz;
        logic               fg;
        pick = $urandom_range(0, 99);
        fg   = ($urandom_range(0, 9) != 0);
        vx   = near_base(org_x);
        vy   = near_base(org_y);
        vz   = near_base(org_z);
        if (pick >= 70 && pick < 85)
        begin
            vx = COORD_W'($urandom_range(0, int'(COORD_MAX)));
            vy = COORD_W'($urandom_range(0, int'(COORD_MAX)));
            vz = COORD_W'($urandom_range(0, int'(COORD_MAX)));
            fg = 1'($urandom_range(0, 1));
        end
        else if (pick >= 85)
        begin
            // push one axis below the region
            axis_pick = $urandom_range(0, 2);
            case (axis_pick)
                0: if (org_x != 0) vx = COORD_W'($urandom_range(0, int'(org_x) - 1));
                1: if (org_y != 0) vy = COORD_W'($urandom_range(0, int'(org_y) - 1));
                default: if (org_z != 0) vz = COORD_W'($urandom_range(0, int'(org_z) - 1));
            endcase
        end
        send_voxel(vx, vy, vz, fg);
    endtask

    // Background voxels and zero face area leave the best at zero
    task automatic test_no_winner();
        send_voxel(9'd0, 9'd0, 9'd0, 1'b0);
        send_voxel(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
        send_voxel(9'd170, 9'd85, 9'd341, 1'b0);
        drain();
        write_reg(CFG_AREA_YZ, 16'd0);
        write_reg(CFG_AREA_XZ, 16'd0);
        write_reg(CFG_AREA_XY, 16'd0);
        send_voxel(9'd0, 9'd0, 9'd0, 1'b1);
        send_voxel(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    endtask

    task automatic test_ties();
        drain();
        write_reg(CFG_AREA_YZ, 16'd512);
        write_reg(CFG_AREA_XZ, 16'd512);
        write_reg(CFG_AREA_XY, 16'd512);
        send_voxel(9'd5, 9'd5, 9'd5, 1'b1);
        send_voxel(9'd6, 9'd7, 9'd8, 1'b1);
        send_voxel(9'd5, 9'd9, 9'd10, 1'b1);
        drain();
        write_reg(CFG_AREA_XY, 16'd2048);
        send_voxel(9'd9, 9'd9, 9'd9, 1'b1);
    endtask

    task automatic test_region_bounds();
        drain();
        set_config(FACE_MAX, 16'd1, 16'd256, 9'd100, 9'd200, 9'd300);
        send_voxel(9'd99, 9'd250, 9'd350, 1'b1);
        send_voxel(9'd150, 9'd199, 9'd350, 1'b1);
        send_voxel(9'd150, 9'd250, 9'd299, 1'b1);
        send_voxel(9'd0, 9'd0, 9'd0, 1'b1);
        send_voxel(9'd100, 9'd200, 9'd300, 1'b1);
        send_voxel(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
        send_voxel(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    endtask

    // Writes past the last register must change nothing
    task automatic test_spare_index();
        drain();
        write_reg(CFG_SPARE_6, FACE_MAX);
        write_reg(CFG_SPARE_7, 16'd0);
        send_voxel(9'd100, 9'd200, 9'd300, 1'b1);
        send_voxel(9'd300, 9'd400, 9'd500, 1'b1);
        send_voxel(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    endtask

    task automatic test_random();
        int phase;
        int n;
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain();
            case (phase)
                0: set_config(FACE_W'($urandom_range(0, 65535)),
                              FACE_W'($urandom_range(0, 65535)),
                              FACE_W'($urandom_range(0, 65535)), 9'd0, 9'd0, 9'd0);
                1: set_config(FACE_MAX, FACE_MAX, FACE_MAX,
                              COORD_W'($urandom_range(0, 64)),
                              COORD_W'($urandom_range(0, 64)),
                              COORD_W'($urandom_range(0, 64)));
                2: set_config(16'd0, 16'd0, 16'd0, 9'd0, 9'd0, 9'd0);
                3: set_config(FACE_W'($urandom_range(0, 65535)),
                              FACE_W'($urandom_range(0, 65535)),
                              FACE_W'($urandom_range(0, 65535)),
                              COORD_MAX, COORD_MAX, COORD_MAX);
                4: set_config(16'd1, 16'd1, 16'd1,
                              COORD_W'($urandom_range(0, 511)),
                              COORD_W'($urandom_range(0, 511)),
                              COORD_W'($urandom_range(0, 511)));
                default: set_config(FACE_W'($urandom_range(0, 65535)),
                                    FACE_W'($urandom_range(0, 65535)),
                                    FACE_W'($urandom_range(0, 65535)),
                                    COORD_W'($urandom_range(0, 511)),
                                    COORD_W'($urandom_range(0, 511)),
                                    COORD_W'($urandom_range(0, 511)));
            endcase
            no_gaps = (phase == 2);
            // stall the result side long enough to back up the input
            if (phase == 0 || phase == 5) hold_req = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++) send_random_voxel();
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin : stimulus
        int i;
        rst_n              = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        vox_bus.valid      = 1'b0;
        vox_bus.vox_x      = '0;
        vox_bus.vox_y      = '0;
        vox_bus.vox_z      = '0;
        vox_bus.inside_req = 1'b0;
        face_yz            = FACE_RESET;
        face_xz            = FACE_RESET;
        face_xy            = FACE_RESET;
        org_x              = '0;
        org_y              = '0;
        org_z              = '0;
        best_now           = '0;
        for (i = 0; i < DIM_SIZE; i++)
        begin
            x_total[i] = '0;
            y_total[i] = '0;
            z_total[i] = '0;
        end
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        test_no_winner();
        test_ties();
        test_region_bounds();
        test_spare_index();
        test_random();
        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : result_sink
        int      gap;
        result_t got;
        result_t want;
        best_bus.ready = 1'b0;
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                gap = HOLD_CYCLES;
            end
            else
            begin
                gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0)
            begin
                best_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            best_bus.ready <= 1'b1;
            @(posedge clk);
            while (best_bus.valid !== 1'b1) @(posedge clk);
            got.best_area  = best_bus.best_area;
            got.best_axis  = best_bus.best_axis;
            got.best_slice = best_bus.best_slice;
            got.found      = best_bus.found;
            if (best_q.size() == 0)
            begin
                error_count++;
                $display("%0t: result with no request pending: expected none, got area %0d",
                         $time, got.best_area);
            end
            else
            begin
                want = best_q.pop_front();
                report_field("best_area", want.best_area, got.best_area);
                report_field("best_axis", AREA_W'(want.best_axis), AREA_W'(got.best_axis));
                report_field("best_slice", AREA_W'(want.best_slice), AREA_W'(got.best_slice));
                report_field("found", AREA_W'(want.found), AREA_W'(got.found));
            end
        end
    end

    // Count cycles in which neither channel moves a request or result; stop past the watchdog limit
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((vox_bus.valid === 1'b1 && vox_bus.ready === 1'b1) ||
                (best_bus.valid === 1'b1 && best_bus.ready === 1'b1))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

/* files.f */
sv/lsat_pkg.sv
sv/lsat_if.sv
sv/lsat_ram.sv
sv/lsat_lane.sv
sv/lsat_outq.sv
sv/largest_slice_area_tracker_top.sv
sim/tb_largest_slice_area_tracker_top.sv
